/* rtl/kngc_pkg.sv */
// Package for the keyboard n-gram metric counter: widths, config register
// indexes, event and history structs, and key geometry helpers.
// No dependencies.
`default_nettype none

package kngc_pkg;

  localparam int unsigned LetterW     = 5;
  localparam int unsigned KeyW        = 5;
  localparam int unsigned ColW        = 4;
  localparam int unsigned FingerW     = 3;
  localparam int unsigned MapLowW     = 60;
  localparam int unsigned MapMidW     = 60;
  localparam int unsigned MapHighW    = 10;
  localparam int unsigned MapW        = MapLowW + MapMidW + MapHighW;
  localparam int unsigned MapIdxW     = 8;
  localparam int unsigned ThreshW     = 4;
  localparam int unsigned CfgDataW    = 60;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CounterBits = 32;
  localparam int unsigned OutW        = 32;
  localparam int unsigned NumCounters = 10;
  localparam int unsigned InDataW     = 8;
  localparam int unsigned OutDataW    = NumCounters * OutW;
  localparam int unsigned HistCntW    = 2;

  localparam logic [LetterW-1:0]  LastLetter  = LetterW'(25);
  localparam logic [KeyW-1:0]     KeyMax      = KeyW'(29);
  localparam logic [ThreshW-1:0]  ThreshReset = ThreshW'(2);
  localparam logic [63:0]         OutMax      = (64'd1 << OutW) - 64'd1;
  localparam logic [FingerW-1:0]  FirstRightFinger = FingerW'(4);

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    RegKeyMapLow     = 2'd0,
    RegKeyMapMid     = 2'd1,
    RegKeyMapHigh    = 2'd2,
    RegStretchThresh = 2'd3
  } cfg_reg_e;

  // one flag per counter, bigram total in bit 0
  typedef struct packed {
    logic one_hand;
    logic redirect;
    logic sfs;
    logic trigram;
    logic stretch;
    logic inroll;
    logic outroll;
    logic alt;
    logic sfb;
    logic bigram;
  } events_t;

  typedef struct packed {
    logic [KeyW-1:0]     last_key;
    logic [KeyW-1:0]     second_last_key;
    logic [HistCntW-1:0] count;
  } history_t;

  // key mod 10, key is at most 29
  function automatic logic [ColW-1:0] col_of(input logic [KeyW-1:0] key);
    logic [KeyW-1:0] r;
    if (key < KeyW'(10))      r = key;
    else if (key < KeyW'(20)) r = key - KeyW'(10);
    else                      r = key - KeyW'(20);
    return ColW'(r);
  endfunction

  // both index columns share a finger on each hand
  function automatic logic [FingerW-1:0] finger_of(input logic [ColW-1:0] col);
    logic [FingerW-1:0] f;
    case (col)
      4'd0:    f = 3'd0;
      4'd1:    f = 3'd1;
      4'd2:    f = 3'd2;
      4'd3:    f = 3'd3;
      4'd4:    f = 3'd3;
      4'd5:    f = 3'd4;
      4'd6:    f = 3'd4;
      4'd7:    f = 3'd5;
      4'd8:    f = 3'd6;
      default: f = 3'd7;
    endcase
    return f;
  endfunction

  function automatic logic hand_of(input logic [ColW-1:0] col);
    return finger_of(col) >= FirstRightFinger;
  endfunction

  // counter value shown on the output, clamped to the output width
  function automatic logic [OutW-1:0] clamp_out(input logic [CounterBits-1:0] c);
    logic [63:0] w;
    w = 64'(c);
    if (w > OutMax) return '1;
    return OutW'(w);
  endfunction

endpackage

`default_nettype wire

/* rtl/kngc_classify.sv */
// Key lookup and bigram/trigram event classification for one letter.
// Depends on kngc_pkg.
`default_nettype none

module kngc_classify (
  input  wire logic [kngc_pkg::LetterW-1:0]  letter_i,
  input  wire logic                          start_i,
  input  wire kngc_pkg::history_t            hist_i,
  input  wire logic [kngc_pkg::MapLowW-1:0]  key_map_low_i,
  input  wire logic [kngc_pkg::MapMidW-1:0]  key_map_mid_i,
  input  wire logic [kngc_pkg::MapHighW-1:0] key_map_high_i,
  input  wire logic [kngc_pkg::ThreshW-1:0]  threshold_i,
  output kngc_pkg::events_t                  events_o,
  output kngc_pkg::history_t                 hist_o
);

  logic [kngc_pkg::MapW-1:0]     key_map;
  logic                          letter_ok;
  logic [kngc_pkg::MapIdxW-1:0]  map_idx;
  logic [kngc_pkg::KeyW-1:0]     key_raw;
  logic [kngc_pkg::KeyW-1:0]     k3;
  logic [kngc_pkg::KeyW-1:0]     k2;
  logic [kngc_pkg::KeyW-1:0]     k1;
  logic [kngc_pkg::HistCntW-1:0] cnt;
  logic [kngc_pkg::ColW-1:0]     c1, c2, c3;
  logic                          h1, h2, h3;
  logic signed [kngc_pkg::ColW:0] d, d1;
  logic [kngc_pkg::ColW-1:0]     gap;
  logic                          is_bigram, is_trigram, same_hand;

  // letter to key
  assign key_map   = {key_map_high_i, key_map_mid_i, key_map_low_i};
  assign letter_ok = letter_i <= kngc_pkg::LastLetter;
  assign map_idx   = letter_ok ? kngc_pkg::MapIdxW'(letter_i) * kngc_pkg::MapIdxW'(5)
                               : '0;
  assign key_raw   = key_map[map_idx +: kngc_pkg::KeyW];
  assign k3        = (key_raw > kngc_pkg::KeyMax) ? kngc_pkg::KeyMax : key_raw;

  // history as seen after an optional start clear
  assign cnt = start_i ? '0 : hist_i.count;
  assign k2  = hist_i.last_key;
  assign k1  = hist_i.second_last_key;

  assign c1 = kngc_pkg::col_of(k1);
  assign c2 = kngc_pkg::col_of(k2);
  assign c3 = kngc_pkg::col_of(k3);
  assign h1 = kngc_pkg::hand_of(c1);
  assign h2 = kngc_pkg::hand_of(c2);
  assign h3 = kngc_pkg::hand_of(c3);

  assign d   = $signed({1'b0, c3}) - $signed({1'b0, c2});
  assign d1  = $signed({1'b0, c2}) - $signed({1'b0, c1});
  assign gap = d[kngc_pkg::ColW] ? kngc_pkg::ColW'(-d) : kngc_pkg::ColW'(d);

  assign is_bigram  = letter_ok && (cnt != '0);
  assign is_trigram = is_bigram && (cnt == kngc_pkg::HistCntW'(2));
  assign same_hand  = (h2 == h3);

  // event flags
  always_comb begin
    events_o          = '0;
    events_o.bigram   = is_bigram;
    events_o.sfb      = is_bigram && (kngc_pkg::finger_of(c2) == kngc_pkg::finger_of(c3));
    events_o.alt      = is_bigram && !same_hand;
    events_o.outroll  = is_bigram && same_hand && (d == 5'sd1);
    events_o.inroll   = is_bigram && same_hand && (d == -5'sd1);
    events_o.stretch  = is_bigram && same_hand && (gap > threshold_i);
    events_o.trigram  = is_trigram;
    events_o.sfs      = is_trigram && (kngc_pkg::finger_of(c1) == kngc_pkg::finger_of(c3));
    if (is_trigram && (h1 == h2) && same_hand) begin
      if (((d1 > 0) && (d < 0)) || ((d1 < 0) && (d > 0))) begin
        events_o.redirect = 1'b1;
      end else begin
        events_o.one_hand = 1'b1;
      end
    end
  end

  // next history; an ignored letter leaves it as is (cleared on start)
  always_comb begin
    if (letter_ok) begin
      hist_o.second_last_key = k2;
      hist_o.last_key        = k3;
      hist_o.count           = (cnt == kngc_pkg::HistCntW'(2)) ? cnt
                                                               : cnt + kngc_pkg::HistCntW'(1);
    end else if (start_i) begin
      hist_o = '0;
    end else begin
      hist_o = hist_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/kngc_counter_bank.sv */
// Ten saturating event counters; they double as the result register.
// Depends on kngc_pkg.
`default_nettype none

module kngc_counter_bank (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            step_i,
  input  wire logic                            clear_i,
  input  wire kngc_pkg::events_t               events_i,
  output logic [kngc_pkg::OutDataW-1:0]        counts_o
);

  logic [kngc_pkg::CounterBits-1:0] cnt_q [kngc_pkg::NumCounters];
  logic [kngc_pkg::CounterBits-1:0] cnt_d [kngc_pkg::NumCounters];
  logic [kngc_pkg::NumCounters-1:0] ev_bits;

  assign ev_bits = events_i;

  // clear on start, then saturating increment
  always_comb begin
    logic [kngc_pkg::CounterBits-1:0] base;
    for (int i = 0; i < kngc_pkg::NumCounters; i++) begin
      base = clear_i ? '0 : cnt_q[i];
      if (ev_bits[i] && (base != '1)) begin
        cnt_d[i] = base + kngc_pkg::CounterBits'(1);
      end else begin
        cnt_d[i] = base;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < kngc_pkg::NumCounters; i++) cnt_q[i] <= '0;
    end else if (step_i) begin
      for (int i = 0; i < kngc_pkg::NumCounters; i++) cnt_q[i] <= cnt_d[i];
    end
  end

  always_comb begin
    for (int i = 0; i < kngc_pkg::NumCounters; i++) begin
      counts_o[i*kngc_pkg::OutW +: kngc_pkg::OutW] = kngc_pkg::clamp_out(cnt_q[i]);
    end
  end

endmodule

`default_nettype wire

/* rtl/keyboard_ngram_metric_counter_top.sv */
// A letter accepted on the stream passes the input register, then the counter/result
// register. Throughput: one letter per cycle while m_axis_tready does not stall the
// output, set by the combinational lookup, classify and counter increment path.
// Reset: counters, key history and valid flags cleared; key maps read as key 0,
// stretch threshold 2.
// Top level: stream handshake, input register, config registers, key history.
// Depends on kngc_pkg, kngc_classify, kngc_counter_bank.
`default_nettype none

module keyboard_ngram_metric_counter_top (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // config write port
  input  wire logic                            cfg_we_i,
  input  wire logic [kngc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [kngc_pkg::CfgDataW-1:0]   cfg_wdata_i,
  // letter stream
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [kngc_pkg::InDataW-1:0]    s_axis_tdata,  // [4:0] letter, rest zero
  input  wire logic [0:0]                      s_axis_tuser,  // [0] start_req
  // counter stream
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // 32 bits each, from bit 0: bigram_total, same_finger_bigrams, alternations,
  // outward_rolls, inward_rolls, lateral_stretches, trigram_total,
  // same_finger_skips, redirects, one_hand_runs
  output logic [kngc_pkg::OutDataW-1:0]        m_axis_tdata
);

  logic [kngc_pkg::MapLowW-1:0]  key_map_low_q;
  logic [kngc_pkg::MapMidW-1:0]  key_map_mid_q;
  logic [kngc_pkg::MapHighW-1:0] key_map_high_q;
  logic [kngc_pkg::ThreshW-1:0]  threshold_q;

  logic                          in_valid_q, in_valid_d;
  logic [kngc_pkg::LetterW-1:0]  letter_q;
  logic                          start_q;
  logic                          out_valid_q, out_valid_d;
  logic                          s_fire, advance;

  kngc_pkg::history_t            hist_q, hist_d;
  kngc_pkg::events_t             events;

  // config register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_map_low_q  <= '0;
      key_map_mid_q  <= '0;
      key_map_high_q <= '0;
      threshold_q    <= kngc_pkg::ThreshReset;
    end else if (cfg_we_i) begin
      unique case (kngc_pkg::cfg_reg_e'(cfg_idx_i))
        kngc_pkg::RegKeyMapLow:     key_map_low_q  <= cfg_wdata_i;
        kngc_pkg::RegKeyMapMid:     key_map_mid_q  <= cfg_wdata_i;
        kngc_pkg::RegKeyMapHigh:    key_map_high_q <= cfg_wdata_i[kngc_pkg::MapHighW-1:0];
        kngc_pkg::RegStretchThresh: threshold_q    <= cfg_wdata_i[kngc_pkg::ThreshW-1:0];
        default: ;
      endcase
    end
  end

  // handshake: the stage moves when the result slot is free or being drained
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_fire)       in_valid_d = 1'b1;
    else if (advance) in_valid_d = 1'b0;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance)            out_valid_d = 1'b1;
    else if (m_axis_tready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      hist_q      <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) hist_q <= hist_d;
    end
  end

  // input payload register
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      letter_q <= s_axis_tdata[kngc_pkg::LetterW-1:0];
      start_q  <= s_axis_tuser[0];
    end
  end

  kngc_classify u_classify (
    .letter_i       (letter_q),
    .start_i        (start_q),
    .hist_i         (hist_q),
    .key_map_low_i  (key_map_low_q),
    .key_map_mid_i  (key_map_mid_q),
    .key_map_high_i (key_map_high_q),
    .threshold_i    (threshold_q),
    .events_o       (events),
    .hist_o         (hist_d)
  );

  kngc_counter_bank u_counter_bank (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .clear_i  (start_q),
    .events_i (events),
    .counts_o (m_axis_tdata)
  );

  assign m_axis_tvalid = out_valid_q;

endmodule

`default_nettype wire

/* tb/keyboard_ngram_metric_counter_top_tb.sv */
// Self-checking testbench for keyboard_ngram_metric_counter_top: letter stream in,
// ten n-gram event counters out, checked against an in-bench typing model.
// Depends on kngc_pkg and the RTL of the top level.
`default_nettype none

module keyboard_ngram_metric_counter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned OutW     = kngc_pkg::OutW;
  localparam int unsigned DataW    = kngc_pkg::OutDataW;
  localparam int unsigned MapW     = kngc_pkg::MapW;
  localparam int          IdleLimit = 2000;
  localparam int          MaxReport = 10;

  // counter slots in the output word, lowest first
  typedef enum int unsigned {
    TlyBigram, TlySameFinger, TlyAlternate, TlyOutRoll, TlyInRoll,
    TlyStretch, TlyTrigram, TlySkip, TlyRedirect, TlyOneHand, TlyCount
  } tally_e;

  typedef struct packed {
    logic [kngc_pkg::LetterW-1:0] letter;
    logic                         start;
  } keystroke_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                             cfg_we    = 1'b0;
  kngc_pkg::cfg_reg_e               cfg_idx   = kngc_pkg::RegKeyMapLow;
  logic [kngc_pkg::CfgDataW-1:0]    cfg_wdata = '0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [kngc_pkg::InDataW-1:0]     s_axis_tdata  = '0;   // [4:0] letter, rest zero
  logic [0:0]                       s_axis_tuser  = '0;   // [0] start_req
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [DataW-1:0]                 m_axis_tdata;   // ten 32-bit counters, bigram_total lowest

  keyboard_ngram_metric_counter_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Typing model: its own copy of the config and history
  // ---------------------------------------------------------------------------
  logic [MapW-1:0]              layout      = '0;      // {high, mid, low}
  logic [kngc_pkg::ThreshW-1:0] stretch_lim = kngc_pkg::ThreshW'(2);
  logic [kngc_pkg::KeyW-1:0]    prev_key    = '0;
  logic [kngc_pkg::KeyW-1:0]    prev2_key   = '0;
  int                           hist_len    = 0;
  logic [OutW-1:0]              tally [TlyCount];

  int finger_lut [10] = '{0, 1, 2, 3, 3, 4, 4, 5, 6, 7};

  string tally_name [TlyCount] = '{"bigram_total", "same_finger_bigrams", "alternations",
                                   "outward_rolls", "inward_rolls", "lateral_stretches",
                                   "trigram_total", "same_finger_skips", "redirects",
                                   "one_hand_runs"};

  initial foreach (tally[i]) tally[i] = '0;

  // qwerty-like placement: top row keys 0..9, home row 10..19, bottom row 20..29
  int unsigned qwerty_keys [26] = '{10, 24, 22, 12, 2, 13, 14, 15, 7, 16, 17, 18, 26,
                                    25, 8, 9, 0, 3, 11, 4, 6, 23, 1, 21, 5, 20};

  function automatic void bump_tally(input tally_e slot);
    if (tally[slot] != '1) tally[slot] = tally[slot] + 1'b1;
  endfunction

  function automatic int key_col(input logic [kngc_pkg::KeyW-1:0] k);
    return int'(k) % 10;
  endfunction

  function automatic int key_hand(input logic [kngc_pkg::KeyW-1:0] k);
    return (finger_lut[key_col(k)] >= 4) ? 1 : 0;
  endfunction

  // apply one letter to the model, return the counter snapshot it shows
  function automatic logic [DataW-1:0] type_letter(input logic [4:0] letter,
                                                   input logic start);
    logic [kngc_pkg::KeyW-1:0] k3;
    logic [DataW-1:0]          snap;
    int                        d, d1, gap;
    if (start) begin
      prev_key  = '0;
      prev2_key = '0;
      hist_len  = 0;
      foreach (tally[i]) tally[i] = '0;
    end
    if (letter <= kngc_pkg::LastLetter) begin
      k3 = layout[int'(letter) * 5 +: 5];
      if (k3 > kngc_pkg::KeyMax) k3 = kngc_pkg::KeyMax;   // codes 30 and 31 fold onto 29
      if (hist_len >= 1) begin
        d   = key_col(k3) - key_col(prev_key);
        gap = (d < 0) ? -d : d;
        bump_tally(TlyBigram);
        if (finger_lut[key_col(prev_key)] == finger_lut[key_col(k3)])
          bump_tally(TlySameFinger);
        if (key_hand(prev_key) != key_hand(k3)) begin
          bump_tally(TlyAlternate);
        end else begin
          if (d == 1) bump_tally(TlyOutRoll);
          else if (d == -1) bump_tally(TlyInRoll);
          if (gap > int'(stretch_lim)) bump_tally(TlyStretch);
        end
        if (hist_len >= 2) begin
          bump_tally(TlyTrigram);
          if (finger_lut[key_col(prev2_key)] == finger_lut[key_col(k3)])
            bump_tally(TlySkip);
          if (key_hand(prev2_key) == key_hand(prev_key) &&
              key_hand(prev_key) == key_hand(k3)) begin
            d1 = key_col(prev_key) - key_col(prev2_key);
            if ((d1 > 0 && d < 0) || (d1 < 0 && d > 0)) bump_tally(TlyRedirect);
            else bump_tally(TlyOneHand);
          end
        end
      end
      prev2_key = prev_key;
      prev_key  = k3;
      if (hist_len < 2) hist_len++;
    end
    for (int j = 0; j < TlyCount; j++) snap[j*OutW +: OutW] = tally[j];
    return snap;
  endfunction

  // ---------------------------------------------------------------------------
  // Letter driver: pops pending keystrokes, random gaps; receiver backpressure
  // ---------------------------------------------------------------------------
  keystroke_t       stroke_q [$];
  logic [DataW-1:0] tally_q  [$];
  logic             in_taken     = 1'b0;
  logic             idle_en      = 1'b1;
  int               stall_cycles = 0;
  int               err_cnt      = 0;

  always @(negedge clk_i) begin
    keystroke_t nxt;
    m_axis_tready <= !idle_en || ($urandom_range(99) >= 33);
    if (!s_axis_tvalid || in_taken) begin
      if (stroke_q.size() != 0 && (!idle_en || $urandom_range(99) >= 33)) begin
        nxt = stroke_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= kngc_pkg::InDataW'(nxt.letter);
        s_axis_tuser  <= nxt.start;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on each input transaction, compare each output transaction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    logic [DataW-1:0] want;
    logic             took_in, took_out;
    took_in  = rst_ni && s_axis_tvalid && s_axis_tready;
    took_out = rst_ni && m_axis_tvalid && m_axis_tready;
    in_taken <= took_in;
    if (took_in)
      tally_q.insert(tally_q.size(), type_letter(s_axis_tdata[4:0], s_axis_tuser[0]));
    if (took_out) begin
      if (tally_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MaxReport)
          $display("ERROR %0t: counter transaction with nothing expected", $realtime);
      end else begin
        want = tally_q.pop_front();
        for (int j = 0; j < TlyCount; j++) begin
          if (m_axis_tdata[j*OutW +: OutW] !== want[j*OutW +: OutW]) begin
            err_cnt++;
            if (err_cnt <= MaxReport)
              $display("ERROR %0t: %0s expected %0d got %0d", $realtime, tally_name[j],
                       want[j*OutW +: OutW], m_axis_tdata[j*OutW +: OutW]);
          end
        end
      end
    end
    stall_cycles <= (took_in || took_out) ? 0 : stall_cycles + 1;
  end

  // watchdog: too long without any transaction
  initial begin
    while (stall_cycles < IdleLimit) @(posedge clk_i);
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic write_reg(input kngc_pkg::cfg_reg_e idx, input logic [59:0] val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    case (idx)
      kngc_pkg::RegKeyMapLow:     layout[59:0]    = val[59:0];
      kngc_pkg::RegKeyMapMid:     layout[119:60]  = val[59:0];
      kngc_pkg::RegKeyMapHigh:    layout[129:120] = val[9:0];
      kngc_pkg::RegStretchThresh: stretch_lim     = val[3:0];
      default: ;
    endcase
  endtask

  task automatic load_layout(input logic [MapW-1:0] m);
    write_reg(kngc_pkg::RegKeyMapLow,  m[59:0]);
    write_reg(kngc_pkg::RegKeyMapMid,  m[119:60]);
    write_reg(kngc_pkg::RegKeyMapHigh, 60'(m[129:120]));
  endtask

  function automatic logic [MapW-1:0] qwerty_layout();
    logic [MapW-1:0] m;
    for (int i = 0; i < 26; i++) m[i*5 +: 5] = 5'(qwerty_keys[i]);
    return m;
  endfunction

  task automatic push_stroke(input int letter, input logic start);
    keystroke_t ks;
    ks.letter = 5'(letter);
    ks.start  = start;
    stroke_q.insert(stroke_q.size(), ks);
  endtask

  // queue a lowercase word, optionally clearing counters on its first letter
  task automatic push_word(input string w, input logic start);
    for (int i = 0; i < w.len(); i++) push_stroke(int'(w[i]) - int'("a"), start && i == 0);
  endtask

  // mostly real letters, a few ignored codes, rare restarts
  task automatic push_random(input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      push_stroke((r < 4) ? $urandom_range(31, 26) : $urandom_range(25, 0),
                  $urandom_range(49) == 0);
    end
  endtask

  // sender holds off until every counter transaction is back
  task automatic wait_drained();
    do @(negedge clk_i);
    while (stroke_q.size() != 0 || s_axis_tvalid || tally_q.size() != 0);
    repeat (3) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [MapW-1:0] rnd_map;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset layout: every letter on key 0; ignored codes and restarts
    push_stroke(0, 1'b0);
    push_stroke(25, 1'b0);
    push_stroke(31, 1'b0);
    push_stroke(26, 1'b1);
    push_stroke(3, 1'b0);
    wait_drained();

    // qwerty: rolls both ways, redirect, alternation, same finger, stretch, skip
    load_layout(qwerty_layout());
    write_reg(kngc_pkg::RegStretchThresh, 60'd2);
    push_word("asdfdsa", 1'b1);
    push_word("qp", 1'b0);
    push_word("ftg", 1'b0);
    push_word("at", 1'b0);
    push_word("fjr", 1'b0);
    wait_drained();

    // random phases over several layouts and thresholds
    for (int p = 0; p < 8; p++) begin
      case (p)
        1:       load_layout('1);                 // every key code 31, folds to 29
        2:       load_layout(qwerty_layout());
        default: begin
          rnd_map = MapW'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
          load_layout(rnd_map);
        end
      endcase
      case (p)
        0:       write_reg(kngc_pkg::RegStretchThresh, 60'd0);
        1:       write_reg(kngc_pkg::RegStretchThresh, 60'd15);
        2:       write_reg(kngc_pkg::RegStretchThresh, 60'd9);
        3:       write_reg(kngc_pkg::RegStretchThresh, 60'd2);
        default: write_reg(kngc_pkg::RegStretchThresh, 60'($urandom_range(15)));
      endcase
      idle_en = (p != 3);   // one phase at full rate on both sides
      push_random(220);
      wait_drained();
    end

    idle_en = 1'b1;
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0 && tally_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
